### rtl/servo_valve_overshoot_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Servo valve overshoot controller: assertion macros
// Concurrent assertion shorthands, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SERVO_VALVE_OVERSHOOT_CONTROLLER_CORE_MACROS_SVH
`define SERVO_VALVE_OVERSHOOT_CONTROLLER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SVOC_CHK_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svoc check failed");

// Consequent must hold in the cycle after the antecedent.
`define SVOC_CHK_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svoc check failed");

`endif

### rtl/svoc_pkg.sv
// ----------------------------------------------------------------------------
// Servo valve overshoot controller: package
// Shared types, register map, command codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package svoc_pkg;

	localparam int unsigned APB_ADDR_W = 5;
	localparam int unsigned APB_DATA_W = 32;

	// Register indexes (byte address is four times the index)
	localparam logic [2:0] REG_NEUTRAL_ANGLE    = 3'd0;
	localparam logic [2:0] REG_LOW_ANGLE        = 3'd1;
	localparam logic [2:0] REG_HIGH_ANGLE       = 3'd2;
	localparam logic [2:0] REG_MIN_PULSE        = 3'd3;
	localparam logic [2:0] REG_MAX_PULSE        = 3'd4;
	localparam logic [2:0] REG_OVERSHOOT_ANGLE  = 3'd5;
	localparam logic [2:0] REG_OVERSHOOT_PERIOD = 3'd6;

	// Command kinds
	localparam logic [2:0] KIND_TICK      = 3'd0;
	localparam logic [2:0] KIND_STATE     = 3'd1;
	localparam logic [2:0] KIND_ABS_GOAL  = 3'd2;
	localparam logic [2:0] KIND_REL_GOAL  = 3'd3;
	localparam logic [2:0] KIND_POLL      = 3'd4;

	// Logical modes
	localparam logic [1:0] MODE_LOW     = 2'd0;
	localparam logic [1:0] MODE_HIGH    = 2'd1;
	localparam logic [1:0] MODE_NEUTRAL = 2'd2;
	localparam logic [1:0] MODE_CUSTOM  = 2'd3;

	// Direction of the last goal change
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

	// floor(n / 180) == (n * RECIP_180) >> RECIP_SHIFT for every n below 2**22
	localparam logic [22:0] RECIP_180   = 23'd5965233;
	localparam int unsigned RECIP_SHIFT = 30;

	// Reset values
	localparam logic [7:0]         RST_NEUTRAL_ANGLE    = 8'd90;
	localparam logic [7:0]         RST_LOW_ANGLE        = 8'd45;
	localparam logic [7:0]         RST_HIGH_ANGLE       = 8'd135;
	localparam logic [11:0]        RST_MIN_PULSE        = 12'd544;
	localparam logic [11:0]        RST_MAX_PULSE        = 12'd2400;
	localparam logic [6:0]         RST_OVERSHOOT_ANGLE  = 7'd0;
	localparam logic [15:0]        RST_OVERSHOOT_PERIOD = 16'd0;
	localparam logic signed [9:0]  RST_GOAL_ANGLE       = 10'sd90;
	localparam logic signed [10:0] RST_COMMANDED_ANGLE  = 11'sd90;

	typedef struct packed {
		logic [7:0]  neutral_angle;
		logic [7:0]  low_angle;
		logic [7:0]  high_angle;
		logic [11:0] min_pulse;
		logic [11:0] max_pulse;
		logic [6:0]  overshoot_angle;
		logic [15:0] overshoot_period;
	} cfg_t;

	// Result fields other than the pulse width, carried down the pipeline
	typedef struct packed {
		logic signed [10:0] set_angle;
		logic               moving;
		logic               changed_flag;
		logic [1:0]         current_mode;
	} res_info_t;

endpackage

`default_nettype wire

### rtl/svoc_ifs.sv
// ----------------------------------------------------------------------------
// Servo valve overshoot controller: stream interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface svoc_cmd_if;
	logic              valid;
	logic              ready;
	logic [2:0]        kind;
	logic signed [8:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface svoc_res_if;
	logic               valid;
	logic               ready;
	logic signed [10:0] set_angle;
	logic signed [15:0] pulse_width;
	logic               moving;
	logic               changed_flag;
	logic [1:0]         current_mode;

	modport source (output valid, output set_angle, output pulse_width, output moving,
		output changed_flag, output current_mode, input ready);
	modport sink   (input valid, input set_angle, input pulse_width, input moving,
		input changed_flag, input current_mode, output ready);
endinterface

`default_nettype wire

### rtl/svoc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Servo valve overshoot controller: configuration registers
// APB register file holding the angle, pulse and overshoot settings.
// ----------------------------------------------------------------------------
`default_nettype none

module svoc_cfg_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [svoc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [svoc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [svoc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	output svoc_pkg::cfg_t                         cfg
);

	svoc_pkg::cfg_t cfg_q;
	logic [2:0]     reg_idx;
	logic           wr_en;

	assign reg_idx = paddr[svoc_pkg::APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.neutral_angle    <= svoc_pkg::RST_NEUTRAL_ANGLE;
			cfg_q.low_angle        <= svoc_pkg::RST_LOW_ANGLE;
			cfg_q.high_angle       <= svoc_pkg::RST_HIGH_ANGLE;
			cfg_q.min_pulse        <= svoc_pkg::RST_MIN_PULSE;
			cfg_q.max_pulse        <= svoc_pkg::RST_MAX_PULSE;
			cfg_q.overshoot_angle  <= svoc_pkg::RST_OVERSHOOT_ANGLE;
			cfg_q.overshoot_period <= svoc_pkg::RST_OVERSHOOT_PERIOD;
		end else if (wr_en) begin
			case (reg_idx)
				svoc_pkg::REG_NEUTRAL_ANGLE:    cfg_q.neutral_angle    <= pwdata[7:0];
				svoc_pkg::REG_LOW_ANGLE:        cfg_q.low_angle        <= pwdata[7:0];
				svoc_pkg::REG_HIGH_ANGLE:       cfg_q.high_angle       <= pwdata[7:0];
				svoc_pkg::REG_MIN_PULSE:        cfg_q.min_pulse        <= pwdata[11:0];
				svoc_pkg::REG_MAX_PULSE:        cfg_q.max_pulse        <= pwdata[11:0];
				svoc_pkg::REG_OVERSHOOT_ANGLE:  cfg_q.overshoot_angle  <= pwdata[6:0];
				svoc_pkg::REG_OVERSHOOT_PERIOD: cfg_q.overshoot_period <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			svoc_pkg::REG_NEUTRAL_ANGLE:    prdata = {24'd0, cfg_q.neutral_angle};
			svoc_pkg::REG_LOW_ANGLE:        prdata = {24'd0, cfg_q.low_angle};
			svoc_pkg::REG_HIGH_ANGLE:       prdata = {24'd0, cfg_q.high_angle};
			svoc_pkg::REG_MIN_PULSE:        prdata = {20'd0, cfg_q.min_pulse};
			svoc_pkg::REG_MAX_PULSE:        prdata = {20'd0, cfg_q.max_pulse};
			svoc_pkg::REG_OVERSHOOT_ANGLE:  prdata = {25'd0, cfg_q.overshoot_angle};
			svoc_pkg::REG_OVERSHOOT_PERIOD: prdata = {16'd0, cfg_q.overshoot_period};
			default:                        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/servo_valve_overshoot_controller_core.sv
// ----------------------------------------------------------------------------
// Servo valve overshoot controller core
// Tracks goal, overshoot timing and change flag; maps the commanded angle to a
// servo pulse width.
// ----------------------------------------------------------------------------
//  Port group   Dir   Handshake                 Beat contents
//  cmd          in    valid/ready               kind, value
//  res          out   valid/ready               set_angle, pulse_width, moving,
//                                               changed_flag, current_mode
//  APB          in    psel/penable, pready=1    register writes and reads
//
//  One command beat in and one result beat out every cycle while res is ready;
//  five registers (input, state update, angle-by-span multiply, reciprocal
//  multiply for /180, offset add) lie between a taken command beat and res.
//  Controller state is updated in the second stage, one beat per cycle unless stalled.
//  A stalled result holds the output; earlier stages keep filling until full.
//  arst_n clears the valid bits and resets the controller state and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_valve_overshoot_controller_core (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [svoc_pkg::APB_ADDR_W-1:0]   paddr,
	input  wire logic [svoc_pkg::APB_DATA_W-1:0]   pwdata,
	output logic      [svoc_pkg::APB_DATA_W-1:0]   prdata,
	output logic                                   pready,
	svoc_cmd_if.sink                               cmd,
	svoc_res_if.source                             res
);

	svoc_pkg::cfg_t cfg;

	svoc_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Pipeline valid bits and load enables
	logic vld_s1, vld_s2, vld_s3, vld_s4, out_vld_q;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_out;

	assign ld_out = !out_vld_q || res.ready;
	assign ld_s4  = !vld_s4 || ld_out;
	assign ld_s3  = !vld_s3 || ld_s4;
	assign ld_s2  = !vld_s2 || ld_s3;
	assign ld_s1  = !vld_s1 || ld_s2;
	assign cmd.ready = ld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (ld_s1)  vld_s1    <= cmd.valid;
			if (ld_s2)  vld_s2    <= vld_s1;
			if (ld_s3)  vld_s3    <= vld_s2;
			if (ld_s4)  vld_s4    <= vld_s3;
			if (ld_out) out_vld_q <= vld_s4;
		end
	end

	// Stage 1: command register
	logic [2:0]        kind_s1;
	logic signed [8:0] value_s1;

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			kind_s1  <= cmd.kind;
			value_s1 <= cmd.value;
		end
	end

	// Controller state
	logic [1:0]         mode_q;
	logic signed [9:0]  goal_q;
	logic signed [10:0] angle_q;
	logic [1:0]         dir_q;
	logic [15:0]        elapsed_q;
	logic               pend_q;

	logic               step_en;
	logic               is_tick, is_state, is_goal, is_poll;
	logic [1:0]         mode_sel;
	logic signed [9:0]  value_ext, state_goal, rel_goal, new_goal;
	logic               goal_chg, refresh, moving_nx, pend_set, flag_nx;
	logic [1:0]         mode_nx, dir_nx;
	logic signed [9:0]  goal_nx;
	logic [15:0]        elapsed_nx;
	logic signed [10:0] ovs, target, angle_nx;

	assign step_en   = vld_s1 && ld_s2;
	assign is_tick   = (kind_s1 == svoc_pkg::KIND_TICK);
	assign is_state  = (kind_s1 == svoc_pkg::KIND_STATE);
	assign is_goal   = (kind_s1 == svoc_pkg::KIND_ABS_GOAL) ||
		(kind_s1 == svoc_pkg::KIND_REL_GOAL);
	assign is_poll   = (kind_s1 == svoc_pkg::KIND_POLL);
	assign value_ext = {value_s1[8], value_s1};

	always_comb begin
		if (value_s1 == 9'sd0) begin
			mode_sel = svoc_pkg::MODE_LOW;
		end else if (value_s1 == 9'sd1) begin
			mode_sel = svoc_pkg::MODE_HIGH;
		end else begin
			mode_sel = svoc_pkg::MODE_NEUTRAL;
		end
	end

	always_comb begin
		case (mode_sel)
			svoc_pkg::MODE_LOW:  state_goal = $signed({2'b00, cfg.low_angle});
			svoc_pkg::MODE_HIGH: state_goal = $signed({2'b00, cfg.high_angle});
			default:             state_goal = $signed({2'b00, cfg.neutral_angle});
		endcase
	end

	assign rel_goal = $signed({2'b00, cfg.neutral_angle}) + value_ext;

	always_comb begin
		if (is_state) begin
			new_goal = state_goal;
		end else if (kind_s1 == svoc_pkg::KIND_REL_GOAL) begin
			new_goal = rel_goal;
		end else begin
			new_goal = value_ext;
		end
	end

	assign goal_chg = (is_state && (mode_sel != mode_q)) || (is_goal && (new_goal != goal_q));
	assign mode_nx  = goal_chg ? (is_state ? mode_sel : svoc_pkg::MODE_CUSTOM) : mode_q;
	assign goal_nx  = goal_chg ? new_goal : goal_q;

	always_comb begin
		if (!goal_chg) begin
			dir_nx = dir_q;
		end else if (new_goal > goal_q) begin
			dir_nx = svoc_pkg::DIR_UP;
		end else if (new_goal < goal_q) begin
			dir_nx = svoc_pkg::DIR_DOWN;
		end else begin
			dir_nx = svoc_pkg::DIR_NONE;
		end
	end

	always_comb begin
		if (goal_chg) begin
			elapsed_nx = '0;
		end else if (is_tick && (elapsed_q != svoc_pkg::ELAPSED_MAX)) begin
			elapsed_nx = elapsed_q + 16'd1;
		end else begin
			elapsed_nx = elapsed_q;
		end
	end

	assign moving_nx = (elapsed_nx < cfg.overshoot_period);

	always_comb begin
		if (moving_nx && (dir_nx == svoc_pkg::DIR_UP)) begin
			ovs = $signed({4'b0000, cfg.overshoot_angle});
		end else if (moving_nx && (dir_nx == svoc_pkg::DIR_DOWN)) begin
			ovs = -$signed({4'b0000, cfg.overshoot_angle});
		end else begin
			ovs = '0;
		end
	end

	// Polls keep the commanded angle; repeated goal or state commands do nothing.
	assign refresh  = is_tick || goal_chg;
	assign target   = {goal_nx[9], goal_nx} + ovs;
	assign angle_nx = refresh ? target : angle_q;
	assign pend_set = refresh && (target != angle_q);
	assign flag_nx  = pend_q || pend_set;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= svoc_pkg::MODE_NEUTRAL;
			goal_q    <= svoc_pkg::RST_GOAL_ANGLE;
			angle_q   <= svoc_pkg::RST_COMMANDED_ANGLE;
			dir_q     <= svoc_pkg::DIR_NONE;
			elapsed_q <= '0;
			pend_q    <= 1'b1;
		end else if (step_en) begin
			mode_q    <= mode_nx;
			goal_q    <= goal_nx;
			angle_q   <= angle_nx;
			dir_q     <= dir_nx;
			elapsed_q <= elapsed_nx;
			pend_q    <= is_poll ? 1'b0 : flag_nx;
		end
	end

	// Stage 2: result fields and the magnitude of the commanded angle
	svoc_pkg::res_info_t info_s2, info_s3, info_s4, out_info_q;
	logic [10:0] mag_s2;
	logic        neg_s2;

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			info_s2.set_angle    <= angle_nx;
			info_s2.moving       <= moving_nx;
			info_s2.changed_flag <= flag_nx;
			info_s2.current_mode <= mode_nx;
			mag_s2               <= angle_nx[10] ? 11'(-angle_nx) : 11'(angle_nx);
			neg_s2               <= angle_nx[10];
		end
	end

	// Stage 3: |angle| * |max_pulse - min_pulse|, below 2**22 for any inputs
	logic        span_neg;
	logic [11:0] span_mag;
	logic [22:0] prod_full;
	logic [21:0] prod_s3;
	logic        neg_s3;

	assign span_neg  = (cfg.max_pulse < cfg.min_pulse);
	assign span_mag  = span_neg ? (cfg.min_pulse - cfg.max_pulse)
		: (cfg.max_pulse - cfg.min_pulse);
	assign prod_full = mag_s2 * span_mag;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			info_s3 <= info_s2;
			prod_s3 <= prod_full[21:0];
			neg_s3  <= neg_s2 ^ span_neg;
		end
	end

	// Stage 4: divide the magnitude by the span of 180 degrees
	logic [44:0] quot_full;
	logic [14:0] quot_s4;
	logic        neg_s4;

	assign quot_full = prod_s3 * svoc_pkg::RECIP_180;

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			info_s4 <= info_s3;
			quot_s4 <= quot_full[svoc_pkg::RECIP_SHIFT +: 15];
			neg_s4  <= neg_s3;
		end
	end

	// Output stage: restore the sign (truncation toward zero) and add the offset
	logic [16:0] quot_ext, pulse_sum;
	logic [15:0] pulse_q;

	assign quot_ext  = {2'b00, quot_s4};
	assign pulse_sum = {5'd0, cfg.min_pulse} + (neg_s4 ? (~quot_ext + 17'd1) : quot_ext);

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_info_q <= info_s4;
			pulse_q    <= pulse_sum[15:0];
		end
	end

	assign res.valid        = out_vld_q;
	assign res.set_angle    = out_info_q.set_angle;
	assign res.pulse_width  = $signed(pulse_q);
	assign res.moving       = out_info_q.moving;
	assign res.changed_flag = out_info_q.changed_flag;
	assign res.current_mode = out_info_q.current_mode;

endmodule

`default_nettype wire

### rtl/svoc_checker.sv
// ----------------------------------------------------------------------------
// Servo valve overshoot controller: port checker
// Watches the command and result channels of the core and flags misbehaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "servo_valve_overshoot_controller_core_macros.svh"

module svoc_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cmd_valid,
	input wire logic              cmd_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire logic signed [10:0] res_set_angle,
	input wire logic signed [15:0] res_pulse_width,
	input wire logic              res_moving,
	input wire logic              res_changed_flag,
	input wire logic [1:0]        res_current_mode
);

	logic               cmd_acc, res_acc;
	logic [2:0]         cnt_q;
	logic               have_q;
	logic signed [10:0] last_angle_q;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	// Command beats accepted but not yet delivered as results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			have_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 3'(cmd_acc) - 3'(res_acc);
			if (res_acc) have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_acc) last_angle_q <= res_set_angle;
	end

	// A result beat must stem from an accepted command beat.
	`SVOC_CHK_IMP(a_no_spurious_result, res_valid, cnt_q != 3'd0)

	// A stalled result beat keeps all of its fields.
	`SVOC_CHK_NXT(a_stall_holds, res_valid && !res_ready, res_valid && $stable(res_set_angle) && $stable(res_pulse_width) && $stable(res_moving) && $stable(res_changed_flag) && $stable(res_current_mode))

	// With the output register empty the whole pipeline can move.
	`SVOC_CHK_IMP(a_ready_when_empty, !res_valid, cmd_ready)

	// A new commanded angle is always reported as a change.
	`SVOC_CHK_IMP(a_change_flagged, res_valid && have_q && (res_set_angle != last_angle_q), res_changed_flag)

endmodule

bind servo_valve_overshoot_controller_core svoc_checker u_svoc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cmd_valid        (cmd.valid),
	.cmd_ready        (cmd.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_set_angle    (res.set_angle),
	.res_pulse_width  (res.pulse_width),
	.res_moving       (res.moving),
	.res_changed_flag (res.changed_flag),
	.res_current_mode (res.current_mode)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo valve overshoot controller core: self-checking testbench
// Drives command beats through the valid/ready channel and compares every
// result beat with a typed table entry or a prediction of the controller. It covers a
// directed table, random traffic under several register settings (zero, full
// bits, typical, inverted pulse range, random) and a run of ticks under the
// longest overshoot period. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module testbench;

	localparam int TICK_RUN = 40;
	localparam int ADDR_W   = svoc_pkg::APB_ADDR_W;
	localparam int DATA_W   = svoc_pkg::APB_DATA_W;

	typedef struct packed {
		logic signed [10:0] set_angle;
		logic signed [15:0] pulse_width;
		logic               moving;
		logic               changed_flag;
		logic [1:0]         current_mode;
	} servo_result_t;

	typedef struct packed {
		logic [2:0]    kind;
		logic [8:0]    value;
		logic          typed;
		servo_result_t want;
	} stim_row_t;

	// Rows with a typed expectation use the reset register values.
	localparam stim_row_t DIRECTED_ROWS [24] = '{
		'{svoc_pkg::KIND_POLL, 9'h000, 1'b1,
			'{11'sd90, 16'sd1472, 1'b0, 1'b1, svoc_pkg::MODE_NEUTRAL}},
		'{svoc_pkg::KIND_POLL, 9'h000, 1'b1,
			'{11'sd90, 16'sd1472, 1'b0, 1'b0, svoc_pkg::MODE_NEUTRAL}},
		'{svoc_pkg::KIND_TICK, 9'h000, 1'b1,
			'{11'sd90, 16'sd1472, 1'b0, 1'b0, svoc_pkg::MODE_NEUTRAL}},
		'{svoc_pkg::KIND_STATE, 9'h000, 1'b1,
			'{11'sd45, 16'sd1008, 1'b0, 1'b1, svoc_pkg::MODE_LOW}},
		'{svoc_pkg::KIND_STATE, 9'h000, 1'b1,
			'{11'sd45, 16'sd1008, 1'b0, 1'b1, svoc_pkg::MODE_LOW}},
		'{svoc_pkg::KIND_POLL, 9'h000, 1'b1,
			'{11'sd45, 16'sd1008, 1'b0, 1'b1, svoc_pkg::MODE_LOW}},
		'{svoc_pkg::KIND_STATE, 9'h001, 1'b1,
			'{11'sd135, 16'sd1936, 1'b0, 1'b1, svoc_pkg::MODE_HIGH}},
		'{svoc_pkg::KIND_STATE, 9'h100, 1'b1,
			'{11'sd90, 16'sd1472, 1'b0, 1'b1, svoc_pkg::MODE_NEUTRAL}},
		'{svoc_pkg::KIND_STATE, 9'h0FF, 1'b0, '0},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h000, 1'b1,
			'{11'sd0, 16'sd544, 1'b0, 1'b1, svoc_pkg::MODE_CUSTOM}},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h0B4, 1'b1,
			'{11'sd180, 16'sd2400, 1'b0, 1'b1, svoc_pkg::MODE_CUSTOM}},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h0B4, 1'b0, '0},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h100, 1'b0, '0},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h0FF, 1'b0, '0},
		'{svoc_pkg::KIND_REL_GOAL, 9'h000, 1'b0, '0},
		'{svoc_pkg::KIND_REL_GOAL, 9'h100, 1'b0, '0},
		'{svoc_pkg::KIND_REL_GOAL, 9'h0FF, 1'b0, '0},
		'{svoc_pkg::KIND_ABS_GOAL, 9'h02D, 1'b0, '0},
		'{svoc_pkg::KIND_STATE, 9'h000, 1'b0, '0},
		'{3'd5, 9'h1FF, 1'b0, '0},
		'{3'd6, 9'h0AA, 1'b0, '0},
		'{3'd7, 9'h155, 1'b0, '0},
		'{svoc_pkg::KIND_POLL, 9'h000, 1'b0, '0},
		'{svoc_pkg::KIND_POLL, 9'h000, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	svoc_cmd_if cmd_if ();
	svoc_res_if res_if ();

	servo_valve_overshoot_controller_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd     (cmd_if),
		.res     (res_if)
	);

	// Register shadow and controller state as the bench sees them.
	svoc_pkg::cfg_t reg_shadow;
	logic [1:0]     mode_now;
	int             goal_deg;
	int             cmd_deg;
	int             dir_sign;
	int             elapsed;
	bit             flag_pending;

	servo_result_t pending_servo_results [$];
	int            failures;
	int            beats_checked;
	int            settings_used;
	bit            source_calm;
	bit            sink_calm;

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("FAIL servo_valve_overshoot_controller_core");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void reset_servo_model();
		reg_shadow.neutral_angle    = svoc_pkg::RST_NEUTRAL_ANGLE;
		reg_shadow.low_angle        = svoc_pkg::RST_LOW_ANGLE;
		reg_shadow.high_angle       = svoc_pkg::RST_HIGH_ANGLE;
		reg_shadow.min_pulse        = svoc_pkg::RST_MIN_PULSE;
		reg_shadow.max_pulse        = svoc_pkg::RST_MAX_PULSE;
		reg_shadow.overshoot_angle  = svoc_pkg::RST_OVERSHOOT_ANGLE;
		reg_shadow.overshoot_period = svoc_pkg::RST_OVERSHOOT_PERIOD;
		mode_now     = svoc_pkg::MODE_NEUTRAL;
		goal_deg     = 90;
		cmd_deg      = 90;
		dir_sign     = 0;
		elapsed      = 0;
		flag_pending = 1'b1;
	endfunction

	function automatic bit overshooting();
		return elapsed < int'(reg_shadow.overshoot_period);
	endfunction

	function automatic void refresh_angle();
		int a;
		a = goal_deg;
		if (overshooting())
			a += dir_sign * int'(reg_shadow.overshoot_angle);
		if (a != cmd_deg) begin
			cmd_deg      = a;
			flag_pending = 1'b1;
		end
	endfunction

	function automatic void retarget(int g);
		dir_sign = (g > goal_deg) ? 1 : ((g < goal_deg) ? -1 : 0);
		goal_deg = g;
		elapsed  = 0;
		refresh_angle();
	endfunction

	function automatic servo_result_t servo_update(logic [2:0] kind, logic [8:0] value);
		servo_result_t r;
		int            v;
		int            g;
		logic [1:0]    m;
		longint        pulse;
		v = int'($signed(value));
		case (kind)
			svoc_pkg::KIND_TICK: begin
				if (elapsed < int'(svoc_pkg::ELAPSED_MAX))
					elapsed++;
				refresh_angle();
			end
			svoc_pkg::KIND_STATE: begin
				m = (v == 0) ? svoc_pkg::MODE_LOW
					: ((v == 1) ? svoc_pkg::MODE_HIGH : svoc_pkg::MODE_NEUTRAL);
				if (m != mode_now) begin
					g = (m == svoc_pkg::MODE_LOW) ? int'(reg_shadow.low_angle)
						: ((m == svoc_pkg::MODE_HIGH) ? int'(reg_shadow.high_angle)
						: int'(reg_shadow.neutral_angle));
					mode_now = m;
					retarget(g);
				end
			end
			svoc_pkg::KIND_ABS_GOAL, svoc_pkg::KIND_REL_GOAL: begin
				g = (kind == svoc_pkg::KIND_REL_GOAL) ? int'(reg_shadow.neutral_angle) + v : v;
				if (g != goal_deg) begin
					mode_now = svoc_pkg::MODE_CUSTOM;
					retarget(g);
				end
			end
			default: ;
		endcase
		r.changed_flag = flag_pending;
		if (kind == svoc_pkg::KIND_POLL)
			flag_pending = 1'b0;
		// SystemVerilog division truncates toward zero, as the block must.
		pulse = longint'(reg_shadow.min_pulse) + (longint'(cmd_deg)
			* (longint'(reg_shadow.max_pulse) - longint'(reg_shadow.min_pulse))) / 180;
		r.set_angle    = cmd_deg[10:0];
		r.pulse_width  = pulse[15:0];
		r.moving       = overshooting();
		r.current_mode = mode_now;
		return r;
	endfunction

	function automatic void shadow_write(int idx, logic [31:0] d);
		case (idx[2:0])
			svoc_pkg::REG_NEUTRAL_ANGLE:    reg_shadow.neutral_angle    = d[7:0];
			svoc_pkg::REG_LOW_ANGLE:        reg_shadow.low_angle        = d[7:0];
			svoc_pkg::REG_HIGH_ANGLE:       reg_shadow.high_angle       = d[7:0];
			svoc_pkg::REG_MIN_PULSE:        reg_shadow.min_pulse        = d[11:0];
			svoc_pkg::REG_MAX_PULSE:        reg_shadow.max_pulse        = d[11:0];
			svoc_pkg::REG_OVERSHOOT_ANGLE:  reg_shadow.overshoot_angle  = d[6:0];
			svoc_pkg::REG_OVERSHOOT_PERIOD: reg_shadow.overshoot_period = d[15:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] shadow_read(int idx);
		case (idx[2:0])
			svoc_pkg::REG_NEUTRAL_ANGLE:    return 32'(reg_shadow.neutral_angle);
			svoc_pkg::REG_LOW_ANGLE:        return 32'(reg_shadow.low_angle);
			svoc_pkg::REG_HIGH_ANGLE:       return 32'(reg_shadow.high_angle);
			svoc_pkg::REG_MIN_PULSE:        return 32'(reg_shadow.min_pulse);
			svoc_pkg::REG_MAX_PULSE:        return 32'(reg_shadow.max_pulse);
			svoc_pkg::REG_OVERSHOOT_ANGLE:  return 32'(reg_shadow.overshoot_angle);
			svoc_pkg::REG_OVERSHOOT_PERIOD: return 32'(reg_shadow.overshoot_period);
			default:                        return '0;
		endcase
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	// ---------------------------------------------------------------- result side

	initial begin
		res_if.ready = 1'b0;
		forever begin : ready_pattern
			int stall;
			int r;
			@(posedge clk);
			r = $urandom_range(0, 99);
			if (sink_calm || r < 70) begin
				res_if.ready <= 1'b1;
			end else begin
				stall = (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
				res_if.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin : result_check
		servo_result_t want;
		if (arst_n && res_if.valid === 1'b1 && res_if.ready) begin
			if (pending_servo_results.size() == 0) begin
				$error("result beat arrived with no expectation waiting");
				failures++;
			end else begin
				want = pending_servo_results.pop_front();
				check_field("set_angle", want.set_angle, res_if.set_angle);
				check_field("pulse_width", want.pulse_width, res_if.pulse_width);
				check_field("moving", want.moving, res_if.moving);
				check_field("changed_flag", want.changed_flag, res_if.changed_flag);
				check_field("current_mode", want.current_mode, res_if.current_mode);
				beats_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- command side

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (source_calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Valid stays high from one beat to the next when there is no gap.
	task automatic send_beat(input logic [2:0] kind, input logic [8:0] value,
		input bit typed, input servo_result_t typed_want);
		servo_result_t r;
		int            gap;
		gap = pick_gap();
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.kind  <= kind;
		cmd_if.value <= value;
		do @(posedge clk); while (!cmd_if.ready);
		r = servo_update(kind, value);
		pending_servo_results.push_back(typed ? typed_want : r);
	endtask

	task automatic run_random(input int count);
		logic [2:0] kind;
		logic [8:0] value;
		int         r;
		int         pick;
		repeat (count) begin
			r     = $urandom_range(0, 99);
			value = 9'($urandom);
			pick  = $urandom_range(0, 3);
			if (r < 40) begin
				kind = svoc_pkg::KIND_TICK;
			end else if (r < 58) begin
				kind = svoc_pkg::KIND_STATE;
				if (pick != 0)
					value = 9'($urandom_range(0, 2));
			end else if (r < 72) begin
				kind = svoc_pkg::KIND_ABS_GOAL;
				// Often aim at an angle already in use, so repeats and equal goals occur.
				case (pick)
					0: value = 9'(reg_shadow.low_angle);
					1: value = 9'(goal_deg);
					default: ;
				endcase
			end else if (r < 86) begin
				kind = svoc_pkg::KIND_REL_GOAL;
				case (pick)
					0: value = 9'(goal_deg - int'(reg_shadow.neutral_angle));
					1: value = 9'($urandom_range(0, 40) - 20);
					default: ;
				endcase
			end else if (r < 96) begin
				kind = svoc_pkg::KIND_POLL;
			end else begin
				kind = 3'($urandom_range(5, 7));
			end
			send_beat(kind, value, 1'b0, '0);
		end
	endtask

	// ---------------------------------------------------------------- register port

	task automatic apb_transfer(input bit wr, input int idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(idx * 4);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		rdata = prdata;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_reg(input int idx, input logic [31:0] data);
		logic [31:0] rd;
		apb_transfer(1'b1, idx, data, rd);
		shadow_write(idx, data);
		if (idx <= int'(svoc_pkg::REG_OVERSHOOT_PERIOD)) begin
			apb_transfer(1'b0, idx, '0, rd);
			check_field("register readback", shadow_read(idx), rd);
		end
	endtask

	// Every beat has a result, so once all have come back the block is idle;
	// the pause covers the pipeline depth all the same.
	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (pending_servo_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_all(input logic [31:0] neutral, input logic [31:0] low,
		input logic [31:0] high, input logic [31:0] pmin, input logic [31:0] pmax,
		input logic [31:0] over, input logic [31:0] period);
		settle();
		program_reg(svoc_pkg::REG_NEUTRAL_ANGLE, neutral);
		program_reg(svoc_pkg::REG_LOW_ANGLE, low);
		program_reg(svoc_pkg::REG_HIGH_ANGLE, high);
		program_reg(svoc_pkg::REG_MIN_PULSE, pmin);
		program_reg(svoc_pkg::REG_MAX_PULSE, pmax);
		program_reg(svoc_pkg::REG_OVERSHOOT_ANGLE, over);
		program_reg(svoc_pkg::REG_OVERSHOOT_PERIOD, period);
		settings_used++;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		cmd_if.valid = 1'b0;
		cmd_if.kind  = svoc_pkg::KIND_TICK;
		cmd_if.value = '0;
		failures      = 0;
		beats_checked = 0;
		settings_used = 1;
		source_calm   = 1'b0;
		sink_calm     = 1'b0;
		reset_servo_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i])
			send_beat(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		run_random(100);

		// All registers at zero; a write past the register list must change nothing.
		program_all('0, '0, '0, '0, '0, '0, '0);
		program_reg(7, 32'hFFFF_FFFF);
		run_random(100);

		// Every bit set, including bits above each register's width.
		program_all('1, '1, '1, '1, '1, '1, '1);
		source_calm = 1'b1;
		run_random(60);
		source_calm = 1'b0;
		run_random(50);

		program_all(90, 20, 160, 500, 2500, 10, 5);
		run_random(110);

		// Inverted pulse range with the largest nominal overshoot.
		program_all(180, 0, 180, 4000, 100, 90, 3);
		sink_calm = 1'b1;
		run_random(110);
		sink_calm = 1'b0;

		for (int p = 0; p < 3; p++) begin
			program_all($urandom_range(0, 180), $urandom_range(0, 180),
				$urandom_range(0, 180), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom_range(0, 90), $urandom_range(1, 12));
			run_random(80);
		end
		program_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		run_random(60);

		// Overshoot held for the longest period; the ticks stay well inside it, so
		// the commanded angle keeps past the goal throughout.
		program_all(90, 45, 135, 544, 2400, 30, 32'hFFFF);
		source_calm = 1'b1;
		sink_calm   = 1'b1;
		send_beat(svoc_pkg::KIND_ABS_GOAL, 9'h064, 1'b0, '0);
		send_beat(svoc_pkg::KIND_ABS_GOAL, 9'h028, 1'b0, '0);
		repeat (TICK_RUN) send_beat(svoc_pkg::KIND_TICK, 9'h000, 1'b0, '0);
		send_beat(svoc_pkg::KIND_POLL, 9'h000, 1'b0, '0);
		source_calm = 1'b0;
		sink_calm   = 1'b0;
		run_random(30);
		cmd_if.valid <= 1'b0;

		while (pending_servo_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("Run covered %0d result beats across %0d register settings,",
			beats_checked, settings_used);
		$display("with a run of %0d ticks under a long overshoot and random stalls.",
			TICK_RUN);
		if (failures == 0)
			$display("PASS servo_valve_overshoot_controller_core");
		else
			$display("FAIL servo_valve_overshoot_controller_core");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/svoc_pkg.sv
rtl/svoc_ifs.sv
rtl/svoc_cfg_regs.sv
rtl/servo_valve_overshoot_controller_core.sv
rtl/svoc_checker.sv
tb/sv/testbench.sv
